FILE: rtl/rmq_pkg.sv
// rmq_pkg: shared types, constants and width helpers for the matrix to
// quaternion converter; no dependencies
package rmq_pkg;

    // field widths of the request and result channels
    localparam int MAT_W = 16;
    localparam int QW_W  = 15;
    localparam int QV_W  = 16;

    // largest magnitude the result fields can carry
    localparam int MAG_FIELD_MAX = 32767;

    // one root lane per quaternion part
    localparam int NUM_LANES = 4;
    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;

    // control and sign bits that travel beside the root lanes
    typedef struct packed {
        logic valid;
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } t_ctl;

    // signed width of 1.0 plus three matrix entries
    function automatic int arg_width(input int frac);
        return ((frac > MAT_W) ? frac : MAT_W) + 3;
    endfunction

    // even width of the shifted root argument
    function automatic int rad_width(input int frac);
        int rw;
        rw = arg_width(frac) - 1 + frac;
        return rw + (rw % 2);
    endfunction

endpackage

FILE: rtl/rmq_if.sv
// rmq_if: valid/ready channel interfaces for matrix requests and quaternion results
// depends on rmq_pkg
interface rmq_in_if;
    import rmq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [MAT_W-1:0] m00;
    logic signed [MAT_W-1:0] m01;
    logic signed [MAT_W-1:0] m02;
    logic signed [MAT_W-1:0] m10;
    logic signed [MAT_W-1:0] m11;
    logic signed [MAT_W-1:0] m12;
    logic signed [MAT_W-1:0] m20;
    logic signed [MAT_W-1:0] m21;
    logic signed [MAT_W-1:0] m22;

    modport source (
        output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
        input  ready
    );
    modport sink (
        input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
        output ready
    );
endinterface

interface rmq_out_if;
    import rmq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic        [QW_W-1:0] quat_w;
    logic signed [QV_W-1:0] quat_x;
    logic signed [QV_W-1:0] quat_y;
    logic signed [QV_W-1:0] quat_z;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z,
        input  ready
    );
    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z,
        output ready
    );
endinterface

FILE: rtl/rmq_root_cell.sv
// rmq_root_cell: one bit of a restoring square root for four lanes, registered
// depends on rmq_pkg
module rmq_root_cell #(
    parameter int RWE = 32,
    parameter int RB  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  rmq_pkg::t_ctl                          i_ctl,
    input  logic [rmq_pkg::NUM_LANES-1:0][RWE-1:0] i_rad,
    input  logic [rmq_pkg::NUM_LANES-1:0][RB+1:0]  i_rem,
    input  logic [rmq_pkg::NUM_LANES-1:0][RB-1:0]  i_root,
    input  logic                                   i_ready_dn,
    output logic                                   o_ready_up,
    output rmq_pkg::t_ctl                          o_ctl,
    output logic [rmq_pkg::NUM_LANES-1:0][RWE-1:0] o_rad,
    output logic [rmq_pkg::NUM_LANES-1:0][RB+1:0]  o_rem,
    output logic [rmq_pkg::NUM_LANES-1:0][RB-1:0]  o_root
);
    import rmq_pkg::*;

    logic                          r_valid;
    logic                          r_neg_x;
    logic                          r_neg_y;
    logic                          r_neg_z;
    logic [NUM_LANES-1:0][RWE-1:0] r_rad;
    logic [NUM_LANES-1:0][RB+1:0]  r_rem;
    logic [NUM_LANES-1:0][RB-1:0]  r_root;
    logic [NUM_LANES-1:0][RWE-1:0] n_rad;
    logic [NUM_LANES-1:0][RB+1:0]  n_rem;
    logic [NUM_LANES-1:0][RB-1:0]  n_root;
    logic [NUM_LANES-1:0][RB+1:0]  rem_sh;
    logic [NUM_LANES-1:0][RB+1:0]  trial;
    logic [NUM_LANES-1:0]          take;

    // stage moves when empty or when the next stage takes its request
    assign o_ready_up = !r_valid || i_ready_dn;

    // bring down two radicand bits and try the next root bit
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            rem_sh[l] = {i_rem[l][RB-1:0], i_rad[l][RWE-1:RWE-2]};
            trial[l]  = {i_root[l], 2'b01};
            take[l]   = rem_sh[l] >= trial[l];
            n_rem[l]  = take[l] ? (rem_sh[l] - trial[l]) : rem_sh[l];
            n_root[l] = {i_root[l][RB-2:0], take[l]};
            n_rad[l]  = {i_rad[l][RWE-3:0], 2'b00};
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready_up) begin
            r_valid <= i_ctl.valid;
        end
        if (o_ready_up) begin
            r_neg_x <= i_ctl.neg_x;
            r_neg_y <= i_ctl.neg_y;
            r_neg_z <= i_ctl.neg_z;
            r_rad   <= n_rad;
            r_rem   <= n_rem;
            r_root  <= n_root;
        end
    end

    assign o_ctl  = '{valid: r_valid, neg_x: r_neg_x, neg_y: r_neg_y, neg_z: r_neg_z};
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

FILE: rtl/rmq_prep.sv
// rmq_prep: input stage, forms the four clamped root arguments and the signs
// depends on rmq_pkg and rmq_if
module rmq_prep #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    rmq_in_if.sink                                 i_req,
    input  logic                                   i_ready_dn,
    output rmq_pkg::t_ctl                          o_ctl,
    output logic [rmq_pkg::NUM_LANES-1:0][rmq_pkg::rad_width(FRAC_BITS)-1:0] o_rad
);
    import rmq_pkg::*;

    localparam int AW  = arg_width(FRAC_BITS);
    localparam int RWE = rad_width(FRAC_BITS);
    localparam logic signed [AW-1:0] C_ONE = AW'(1 << FRAC_BITS);

    logic signed [AW-1:0]          a00;
    logic signed [AW-1:0]          a11;
    logic signed [AW-1:0]          a22;
    logic signed [AW-1:0]          arg [NUM_LANES];
    logic [NUM_LANES-1:0][RWE-1:0] n_rad;
    logic [NUM_LANES-1:0][RWE-1:0] r_rad;
    logic                          r_valid;
    logic                          r_neg_x;
    logic                          r_neg_y;
    logic                          r_neg_z;
    logic                          ready_up;

    assign ready_up    = !r_valid || i_ready_dn;
    assign i_req.ready = ready_up;

    // one plus or minus the diagonal for each quaternion part
    always_comb begin
        a00 = AW'(i_req.m00);
        a11 = AW'(i_req.m11);
        a22 = AW'(i_req.m22);
        arg[LANE_W] = C_ONE + a00 + a11 + a22;
        arg[LANE_X] = C_ONE + a00 - a11 - a22;
        arg[LANE_Y] = C_ONE - a00 + a11 - a22;
        arg[LANE_Z] = C_ONE - a00 - a11 + a22;
        for (int l = 0; l < NUM_LANES; l++) begin
            // clamp non-positive arguments to zero, then scale by 1.0
            if (arg[l] > 0) begin
                n_rad[l] = RWE'({arg[l][AW-2:0], {FRAC_BITS{1'b0}}});
            end else begin
                n_rad[l] = '0;
            end
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready_up) begin
            r_valid <= i_req.valid;
        end
        if (ready_up) begin
            r_neg_x <= i_req.m21 < i_req.m12;
            r_neg_y <= i_req.m02 < i_req.m20;
            r_neg_z <= i_req.m10 < i_req.m01;
            r_rad   <= n_rad;
        end
    end

    assign o_ctl = '{valid: r_valid, neg_x: r_neg_x, neg_y: r_neg_y, neg_z: r_neg_z};
    assign o_rad = r_rad;

endmodule

FILE: rtl/rotation_matrix_to_quaternion_core.sv
// rotation_matrix_to_quaternion_core: one argument stage, one root cell per
// root bit, one output register. Throughput is one request per cycle while the
// output is not stalled; each stage moves when its successor can take its
// content, so bubbles close up under stall.
// Synchronous active-low reset clears the stage valid bits only; no warm-up pass.
// depends on rmq_pkg, rmq_if, rmq_prep and rmq_root_cell
module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmq_in_if.sink     i_in,
    rmq_out_if.source  o_out
);
    import rmq_pkg::*;

    localparam int RWE     = rad_width(FRAC_BITS);
    localparam int RB      = RWE / 2;
    localparam int MW      = (RB - 1 > QV_W) ? RB - 1 : QV_W;
    localparam int SAT_INT = ((1 << FRAC_BITS) < MAG_FIELD_MAX) ?
                             (1 << FRAC_BITS) : MAG_FIELD_MAX;

    t_ctl                          ctl_c   [RB+1];
    logic [NUM_LANES-1:0][RWE-1:0] rad_c   [RB+1];
    logic [NUM_LANES-1:0][RB+1:0]  rem_c   [RB+1];
    logic [NUM_LANES-1:0][RB-1:0]  root_c  [RB+1];
    logic [RB:0]                   ready_c;

    logic                          r_out_valid;
    logic [QW_W-1:0]               r_quat_w;
    logic signed [QV_W-1:0]        r_quat_x;
    logic signed [QV_W-1:0]        r_quat_y;
    logic signed [QV_W-1:0]        r_quat_z;
    logic [QW_W-1:0]               n_quat_w;
    logic signed [QV_W-1:0]        n_quat_x;
    logic signed [QV_W-1:0]        n_quat_y;
    logic signed [QV_W-1:0]        n_quat_z;
    logic [MW-1:0]                 mag_ext [NUM_LANES];
    logic [QW_W-1:0]               mag     [NUM_LANES];
    logic                          out_ready_up;

    // argument stage
    rmq_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_in),
        .i_ready_dn (ready_c[0]),
        .o_ctl      (ctl_c[0]),
        .o_rad      (rad_c[0])
    );

    // root starts from an empty remainder and root
    assign rem_c[0]  = '0;
    assign root_c[0] = '0;

    // chain of root cells, most significant root bit first
    for (genvar k = 0; k < RB; k++) begin : g_cell
        rmq_root_cell #(
            .RWE (RWE),
            .RB  (RB)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl_c[k]),
            .i_rad      (rad_c[k]),
            .i_rem      (rem_c[k]),
            .i_root     (root_c[k]),
            .i_ready_dn (ready_c[k+1]),
            .o_ready_up (ready_c[k]),
            .o_ctl      (ctl_c[k+1]),
            .o_rad      (rad_c[k+1]),
            .o_rem      (rem_c[k+1]),
            .o_root     (root_c[k+1])
        );
    end

    assign out_ready_up = !r_out_valid || o_out.ready;
    assign ready_c[RB]  = out_ready_up;

    // halve the root, saturate, apply the signs
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            mag_ext[l] = MW'(root_c[RB][l] >> 1);
            mag[l] = (mag_ext[l] > MW'(SAT_INT)) ? QW_W'(SAT_INT) : mag_ext[l][QW_W-1:0];
        end
        n_quat_w = mag[LANE_W];
        n_quat_x = ctl_c[RB].neg_x ? $signed(QV_W'(0) - {1'b0, mag[LANE_X]})
                                   : $signed({1'b0, mag[LANE_X]});
        n_quat_y = ctl_c[RB].neg_y ? $signed(QV_W'(0) - {1'b0, mag[LANE_Y]})
                                   : $signed({1'b0, mag[LANE_Y]});
        n_quat_z = ctl_c[RB].neg_z ? $signed(QV_W'(0) - {1'b0, mag[LANE_Z]})
                                   : $signed({1'b0, mag[LANE_Z]});
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready_up) begin
            r_out_valid <= ctl_c[RB].valid;
        end
        if (out_ready_up) begin
            r_quat_w <= n_quat_w;
            r_quat_x <= n_quat_x;
            r_quat_y <= n_quat_y;
            r_quat_z <= n_quat_z;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.quat_w = r_quat_w;
    assign o_out.quat_x = r_quat_x;
    assign o_out.quat_y = r_quat_y;
    assign o_out.quat_z = r_quat_z;

`ifndef ASSERT_OFF
    localparam logic signed [QV_W-1:0] SAT_S = QV_W'(SAT_INT);

    // an accepted request lands in the argument stage
    a_req_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> ctl_c[0].valid)
        else $error("accepted request lost at argument stage");

    // a finished root moves into the output register when it is free
    a_out_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl_c[RB].valid && out_ready_up) |=> o_out.valid)
        else $error("finished root not loaded into output register");

    // scalar part stays within the saturation bound
    a_w_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.quat_w <= QW_W'(SAT_INT)))
        else $error("quat_w above saturation bound");

    // vector parts stay within the saturation bound
    a_xyz_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.quat_x <= SAT_S) && (o_out.quat_x >= -SAT_S) &&
                         (o_out.quat_y <= SAT_S) && (o_out.quat_y >= -SAT_S) &&
                         (o_out.quat_z <= SAT_S) && (o_out.quat_z >= -SAT_S)))
        else $error("vector part above saturation bound");
`endif

endmodule

FILE: test/rotation_matrix_to_quaternion_core_test.sv
// rotation_matrix_to_quaternion_core_test: self-checking bench for the matrix to quaternion core
// drives matrix requests with random idling, predicts each quaternion and checks it in order
// depends on rmq_pkg, rmq_if and rotation_matrix_to_quaternion_core
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_core_test;
    import rmq_pkg::*;

    localparam int  FRAC      = 14;
    localparam int  N_RANDOM  = 400;
    localparam int  HOLD_LEN  = 150;
    localparam int  DRAIN_LEN = 40;

    typedef struct packed {
        logic signed [MAT_W-1:0] m00, m01, m02;
        logic signed [MAT_W-1:0] m10, m11, m12;
        logic signed [MAT_W-1:0] m20, m21, m22;
    } mat_t;

    typedef struct packed {
        logic        [QW_W-1:0] w;
        logic signed [QV_W-1:0] x;
        logic signed [QV_W-1:0] y;
        logic signed [QV_W-1:0] z;
    } quat_t;

    // quaternion predictor and in-order result store
    class quat_scoreboard;
        quat_t expected_quats[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        // floor(isqrt(arg << FRAC) / 2), clamped at zero below and 1.0 above
        function automatic logic [QV_W-1:0] half_root_mag(longint arg);
            longint unsigned v;
            longint unsigned r;
            longint unsigned b;
            if (arg <= 0) return '0;
            v = longint'(arg) << FRAC;
            r = '0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            r = r >> 1;
            if (r > (64'd1 << FRAC)) r = 64'd1 << FRAC;
            if (r > 64'(MAG_FIELD_MAX)) r = 64'(MAG_FIELD_MAX);
            return r[QV_W-1:0];
        endfunction

        // negative difference flips the part, zero stays positive
        function automatic logic [QV_W-1:0] signed_part(logic [QV_W-1:0] mag, longint diff);
            return (diff < 0) ? -mag : mag;
        endfunction

        function automatic quat_t quat_from_matrix(mat_t m);
            longint one;
            longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
            logic [QV_W-1:0] mw;
            quat_t q;
            one = longint'(1) << FRAC;
            a00 = longint'(m.m00); a01 = longint'(m.m01); a02 = longint'(m.m02);
            a10 = longint'(m.m10); a11 = longint'(m.m11); a12 = longint'(m.m12);
            a20 = longint'(m.m20); a21 = longint'(m.m21); a22 = longint'(m.m22);
            mw  = half_root_mag(one + a00 + a11 + a22);
            q.w = mw[QW_W-1:0];
            q.x = signed_part(half_root_mag(one + a00 - a11 - a22), a21 - a12);
            q.y = signed_part(half_root_mag(one - a00 + a11 - a22), a02 - a20);
            q.z = signed_part(half_root_mag(one - a00 - a11 + a22), a10 - a01);
            return q;
        endfunction

        function void note_request(mat_t m);
            expected_quats.push_back(quat_from_matrix(m));
        endfunction

        function void check_result(quat_t got);
            quat_t want;
            if (expected_quats.size() == 0) begin
                $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d",
                         $time, got.w, got.x, got.y, got.z);
                errors++;
                return;
            end
            want = expected_quats.pop_front();
            if (got !== want) begin
                $display({"%0t: quaternion mismatch, expected w=%0d x=%0d y=%0d z=%0d,",
                          " got w=%0d x=%0d y=%0d z=%0d"},
                         $time, want.w, want.x, want.y, want.z,
                         got.w, got.x, got.y, got.z);
                errors++;
            end
        endfunction

        function int pending();
            return expected_quats.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rmq_in_if  req_if();
    rmq_out_if res_if();

    rotation_matrix_to_quaternion_core #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    quat_scoreboard sb = new();

    // idling controls shared by sender and receiver
    bit quiet;
    int hold_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // offer one request and wait until it is taken
    task automatic send_matrix(input mat_t m);
        req_if.valid <= 1'b1;
        req_if.m00 <= m.m00; req_if.m01 <= m.m01; req_if.m02 <= m.m02;
        req_if.m10 <= m.m10; req_if.m11 <= m.m11; req_if.m12 <= m.m12;
        req_if.m20 <= m.m20; req_if.m21 <= m.m21; req_if.m22 <= m.m22;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(m);
        @(negedge i_clk);
    endtask

    // random sender gap
    task automatic sender_idle();
        int n;
        if (quiet || $urandom_range(0, 5) != 0) return;
        n = $urandom_range(1, 11);
        req_if.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic mat_t matrix_of(int a00, int a01, int a02, int a10, int a11,
                                       int a12, int a20, int a21, int a22);
        mat_t m;
        m.m00 = MAT_W'(a00); m.m01 = MAT_W'(a01); m.m02 = MAT_W'(a02);
        m.m10 = MAT_W'(a10); m.m11 = MAT_W'(a11); m.m12 = MAT_W'(a12);
        m.m20 = MAT_W'(a20); m.m21 = MAT_W'(a21); m.m22 = MAT_W'(a22);
        return m;
    endfunction

    function automatic logic signed [MAT_W-1:0] to_q14(real v);
        int k;
        k = $rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5));
        if (k > 16384) k = 16384;
        if (k < -16384) k = -16384;
        return MAT_W'(k);
    endfunction

    // proper rotation built from a random unit quaternion
    function automatic mat_t rotation_matrix();
        real a, b, c, d, n;
        mat_t m;
        a = real'(int'($urandom_range(0, 2000)) - 1000);
        b = real'(int'($urandom_range(0, 2000)) - 1000);
        c = real'(int'($urandom_range(0, 2000)) - 1000);
        d = real'(int'($urandom_range(0, 2000)) - 1000);
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n == 0.0) begin
            a = 1.0;
            n = 1.0;
        end
        a = a / n; b = b / n; c = c / n; d = d / n;
        m.m00 = to_q14(1.0 - 2.0 * (c * c + d * d));
        m.m01 = to_q14(2.0 * (b * c - a * d));
        m.m02 = to_q14(2.0 * (b * d + a * c));
        m.m10 = to_q14(2.0 * (b * c + a * d));
        m.m11 = to_q14(1.0 - 2.0 * (b * b + d * d));
        m.m12 = to_q14(2.0 * (c * d - a * b));
        m.m20 = to_q14(2.0 * (b * d - a * c));
        m.m21 = to_q14(2.0 * (c * d + a * b));
        m.m22 = to_q14(1.0 - 2.0 * (b * b + c * c));
        return m;
    endfunction

    // one entry, within -1.0..1.0 or anywhere in the field
    function automatic logic signed [MAT_W-1:0] noise_entry(bit wide);
        if (wide) return MAT_W'($urandom());
        return MAT_W'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    // unstructured matrix, mostly within -1.0..1.0, sometimes the full field
    function automatic mat_t noise_matrix();
        mat_t m;
        bit   wide;
        wide = ($urandom_range(0, 3) == 0);
        m.m00 = noise_entry(wide);
        m.m01 = noise_entry(wide);
        m.m02 = noise_entry(wide);
        m.m10 = noise_entry(wide);
        m.m11 = noise_entry(wide);
        m.m12 = noise_entry(wide);
        m.m20 = noise_entry(wide);
        m.m21 = noise_entry(wide);
        m.m22 = noise_entry(wide);
        // equal off-diagonal pairs give zero differences
        if ($urandom_range(0, 5) == 0) m.m21 = m.m12;
        if ($urandom_range(0, 5) == 0) m.m02 = m.m20;
        if ($urandom_range(0, 5) == 0) m.m10 = m.m01;
        return m;
    endfunction

    // receiver: random ready bursts, one long hold-off, checks on every result
    initial begin
        int stall_left;
        quat_t got;
        res_if.ready = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got.w = res_if.quat_w;
                got.x = res_if.quat_x;
                got.y = res_if.quat_y;
                got.z = res_if.quat_z;
                sb.check_result(got);
            end
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                res_if.ready <= 1'b0;
            end else if (quiet) begin
                res_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        mat_t directed_set[$];
        mat_t m;
        quiet = 1'b0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.m00 = '0; req_if.m01 = '0; req_if.m02 = '0;
        req_if.m10 = '0; req_if.m11 = '0; req_if.m12 = '0;
        req_if.m20 = '0; req_if.m21 = '0; req_if.m22 = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // identity and zero matrix
        directed_set.push_back(matrix_of(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        directed_set.push_back(matrix_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // half turns about each axis
        directed_set.push_back(matrix_of(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        directed_set.push_back(matrix_of(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
        directed_set.push_back(matrix_of(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        // quarter-ish turns with positive and negative differences
        directed_set.push_back(matrix_of(11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384));
        directed_set.push_back(matrix_of(11585, 11585, 0, -11585, 11585, 0, 0, 0, 16384));
        directed_set.push_back(matrix_of(16384, 0, 0, 0, 0, -16384, 0, 16384, 0));
        directed_set.push_back(matrix_of(16384, 0, 0, 0, 0, 16384, 0, -16384, 0));
        directed_set.push_back(matrix_of(0, 0, 16384, 0, 16384, 0, -16384, 0, 0));
        directed_set.push_back(matrix_of(0, 0, -16384, 0, 16384, 0, 16384, 0, 0));
        // all entries at the range ends
        directed_set.push_back(matrix_of(16384, 16384, 16384, 16384, 16384, 16384,
                                         16384, 16384, 16384));
        directed_set.push_back(matrix_of(-16384, -16384, -16384, -16384, -16384, -16384,
                                         -16384, -16384, -16384));
        // zero differences with nonzero magnitudes
        directed_set.push_back(matrix_of(0, 5000, -7000, 5000, 0, 3000, -7000, 3000, 0));
        // negative arguments clamp to zero
        directed_set.push_back(matrix_of(-16384, 100, 200, 300, -16384, 400, 500, 600, 16384));
        directed_set.push_back(matrix_of(-10000, 0, 0, 0, -10000, 0, 0, 0, -10000));
        // oversized entries saturate the magnitude
        directed_set.push_back(matrix_of(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
        directed_set.push_back(matrix_of(32767, -32768, 32767, 32767, -32768, -32768,
                                         -32768, 32767, -32768));
        directed_set.push_back(matrix_of(-32768, 32767, -32768, -32768, -32768, 32767,
                                         32767, -32768, 32767));
        // small magnitudes
        directed_set.push_back(matrix_of(-16383, 1, -1, -1, -16383, 1, 1, -1, 16383));
        directed_set.push_back(matrix_of(1, -1, 1, 1, 1, -1, -1, 1, 1));
        foreach (directed_set[i]) begin
            send_matrix(directed_set[i]);
            sender_idle();
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 120) hold_cycles = HOLD_LEN;
            if (k == N_RANDOM - 60) quiet = 1'b1;
            m = ($urandom_range(0, 1) == 0) ? rotation_matrix() : noise_matrix();
            send_matrix(m);
            if (k == 240) begin
                // let the pipeline drain completely before going on
                req_if.valid <= 1'b0;
                while (sb.pending() > 0) @(posedge i_clk);
                @(negedge i_clk);
            end else begin
                sender_idle();
            end
        end
        req_if.valid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
